### hw/rtl/utd_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; imported by every other file of the block.
package utd_pkg;

  // Byte classification masks and patterns
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContPat    = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Pat   = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Pat   = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Pat   = 8'hF0;

  localparam logic [20:0] BmpMax     = 21'h00FFFF;
  localparam logic [20:0] SuppBase   = 21'h010000;
  localparam logic [15:0] SurrHiBase = 16'hD800;
  localparam logic [15:0] SurrLoBase = 16'hDC00;
  localparam logic [15:0] LimitMax   = 16'hFFFF;

  // Decoupling queue depth between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One queue entry: the units caused by one accepted byte
  typedef struct packed {
    logic [1:0]  n_data;   // data units carried, 0..2
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        term;     // terminator follows the data units
    logic [16:0] total;    // count reported on the terminator
    logic        stopped;  // halted by a bad or cut-off sequence
  } utd_entry_t;

endpackage

### hw/rtl/utd_front.sv
// Front end: classifies each UTF-8 byte, tracks sequence state and builds
// one queue entry per byte. Depends on utd_pkg.
module utd_front import utd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        take_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  output logic        ent_valid_o,
  output utd_entry_t  ent_o
);

  logic [1:0]  pend_q, pend_d;
  logic [20:0] acc_q, acc_d;
  logic [15:0] uw_q, uw_d;
  logic        halt_q, halt_d;
  logic [15:0] limit_q, limit_d;

  logic [16:0] cap_m1;
  logic [20:0] acc_next;
  logic [20:0] cp;
  logic [20:0] supp_off;
  logic        emit;
  utd_entry_t  ent;

  // data-unit limit = capacity - 1, saturated, zero capacity -> 0
  assign cap_m1 = cfg_wdata_i - 17'd1;
  always_comb begin
    if (cfg_wdata_i == 17'd0) begin
      limit_d = 16'd0;
    end else if (cap_m1[16]) begin
      limit_d = LimitMax;
    end else begin
      limit_d = cap_m1[15:0];
    end
  end

  assign acc_next = {acc_q[14:0], data_byte_i[5:0]};
  assign cp       = acc_next;
  assign supp_off = cp - SuppBase;

  always_comb begin
    pend_d = pend_q;
    acc_d  = acc_q;
    uw_d   = uw_q;
    halt_d = halt_q;
    emit   = 1'b0;
    ent    = '0;

    if (data_byte_i != 8'd0 && !halt_q) begin
      if (pend_q != 2'd0) begin
        if ((data_byte_i & ContMask) == ContPat) begin
          pend_d = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            emit  = 1'b1;
            acc_d = '0;
          end else begin
            acc_d = acc_next;
          end
        end else begin
          // broken sequence: drop partial point, halt until string end
          halt_d = 1'b1;
          pend_d = 2'd0;
          acc_d  = '0;
        end
      end else if (uw_q < limit_q) begin
        if (!data_byte_i[7]) begin
          ent.n_data = 2'd1;
          ent.unit0  = {8'h00, data_byte_i};
        end else if ((data_byte_i & Lead2Mask) == Lead2Pat) begin
          acc_d  = {16'h0000, data_byte_i[4:0]};
          pend_d = 2'd1;
        end else if ((data_byte_i & Lead3Mask) == Lead3Pat) begin
          acc_d  = {17'd0, data_byte_i[3:0]};
          pend_d = 2'd2;
        end else if ((data_byte_i & Lead4Mask) == Lead4Pat) begin
          acc_d  = {18'd0, data_byte_i[2:0]};
          pend_d = 2'd3;
        end
      end
    end

    if (emit) begin
      if (cp > BmpMax) begin
        if (({1'b0, uw_q} + 17'd1) < {1'b0, limit_q}) begin
          ent.n_data = 2'd2;
          ent.unit0  = SurrHiBase + {5'b00000, supp_off[20:10]};
          ent.unit1  = SurrLoBase + {6'b000000, supp_off[9:0]};
        end
      end else if (uw_q < limit_q) begin
        ent.n_data = 2'd1;
        ent.unit0  = cp[15:0];
      end
    end

    uw_d = uw_q + {14'd0, ent.n_data};

    if (data_byte_i == 8'd0 || end_of_string_i) begin
      ent.term    = 1'b1;
      ent.total   = {1'b0, uw_d} + 17'd1;
      ent.stopped = halt_d | (pend_d != 2'd0);
      pend_d = 2'd0;
      acc_d  = '0;
      uw_d   = '0;
      halt_d = 1'b0;
    end
  end

  assign ent_o       = ent;
  assign ent_valid_o = take_i && ((ent.n_data != 2'd0) || ent.term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      acc_q   <= '0;
      uw_q    <= '0;
      halt_q  <= 1'b0;
      limit_q <= LimitMax;
    end else begin
      if (cfg_we_i) begin
        limit_q <= limit_d;
      end
      if (take_i) begin
        pend_q <= pend_d;
        acc_q  <= acc_d;
        uw_q   <= uw_d;
        halt_q <= halt_d;
      end
    end
  end

endmodule

### hw/rtl/utd_fifo.sv
// Short entry queue decoupling front end from back end.
// Depends on utd_pkg for the entry type and depth.
module utd_fifo import utd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  utd_entry_t wdata_i,
  input  logic       rd_i,
  output utd_entry_t rdata_o,
  output logic       full_o,
  output logic       empty_o
);

  utd_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= wptr_q + QPtrW'(1);
      end
      if (rd_i) begin
        rptr_q <= rptr_q + QPtrW'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (!wr_i && rd_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

### hw/rtl/utd_back.sv
// Back end: walks the units of the head queue entry, one result beat per pop.
// Depends on utd_pkg for the entry type.
module utd_back import utd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  utd_entry_t  head_i,
  input  logic        head_empty_i,
  input  logic        pop_i,
  output logic        head_pop_o,
  output logic [15:0] code_unit_o,
  output logic        last_o,
  output logic [16:0] total_units_o,
  output logic        stopped_early_o
);

  logic [1:0] idx_q, idx_d;
  logic [1:0] n_units;
  logic       is_data;
  logic       last_beat;
  logic       beat;

  assign n_units   = head_i.n_data + {1'b0, head_i.term};
  assign is_data   = (idx_q < head_i.n_data);
  assign last_beat = (idx_q == (n_units - 2'd1));
  assign beat      = pop_i && !head_empty_i;
  assign head_pop_o = beat && last_beat;

  always_comb begin
    if (is_data) begin
      code_unit_o     = (idx_q == 2'd0) ? head_i.unit0 : head_i.unit1;
      last_o          = 1'b0;
      total_units_o   = '0;
      stopped_early_o = 1'b0;
    end else begin
      code_unit_o     = '0;
      last_o          = 1'b1;
      total_units_o   = head_i.total;
      stopped_early_o = head_i.stopped;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (beat) begin
      idx_d = last_beat ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

### hw/rtl/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 decoder, top level.
// Depends on utd_pkg, utd_front, utd_fifo and utd_back.
//
// Usage:
//  - Input is a queue write port: a byte beat (data_byte_i, end_of_string_i)
//    is taken at a clock edge with push high and full low. One byte per
//    cycle is sustained; full rises only when the entry queue is backed up.
//  - Output is a queue read port: while empty is low the oldest UTF-16 unit
//    sits on code_unit_o/last_o/total_units_o/stopped_early_o, and a pop at
//    that edge consumes it. One unit per cycle leaves while pop is high and empty is low.
//  - A byte's units are registered in the queue, behind any units still queued.
//  - A byte yields 0 to 3 units (surrogate pair plus terminator at most);
//    those go out over consecutive pops, so a stalled reader fills the
//    4-entry queue and then pushes back through full.
//  - The capacity register (cfg_we_i/cfg_wdata_i) is to be written only while
//    the block is idle, which it does not check; reset sets it to 65536 units.
//  - Reset clears sequence state, unit count and the queue; no clearing
//    pass is needed, the block takes bytes in the first cycle after reset.
module utf8_to_utf16_decoder import utd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit_o,
  output logic        last_o,
  output logic [16:0] total_units_o,
  output logic        stopped_early_o
);

  logic       take;
  logic       ent_valid;
  utd_entry_t ent;
  utd_entry_t head;
  logic       head_pop;

  // byte beat accepted
  assign take = push && !full;

  utd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .take_i         (take),
    .data_byte_i    (data_byte_i),
    .end_of_string_i(end_of_string_i),
    .ent_valid_o    (ent_valid),
    .ent_o          (ent)
  );

  // bytes producing no unit never occupy a slot
  utd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (ent_valid),
    .wdata_i(ent),
    .rd_i   (head_pop),
    .rdata_o(head),
    .full_o (full),
    .empty_o(empty)
  );

  utd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_empty_i   (empty),
    .pop_i          (pop),
    .head_pop_o     (head_pop),
    .code_unit_o    (code_unit_o),
    .last_o         (last_o),
    .total_units_o  (total_units_o),
    .stopped_early_o(stopped_early_o)
  );

endmodule
